[rtl/xtea_block_cipher_core_assert.svh]
// assertion macros shared by the xtea rtl files
// each one expands to a clocked property on clk with rst_n as disable
`ifndef XTEA_BLOCK_CIPHER_CORE_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTH

`define XTEA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xtea assertion failed");

`define XTEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xtea assertion failed");

`define XTEA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("xtea assertion failed");

`else

`define XTEA_ASSERT_SAME(lbl, ante, cons)
`define XTEA_ASSERT_NEXT(lbl, ante, cons)
`define XTEA_ASSERT_NEVER(lbl, cond)

`endif

`endif

[rtl/xtea_pkg.sv]
// shared types, constants and round helpers for the xtea cipher core
// no dependencies
`timescale 1ns / 1ps

package xtea_pkg;

    localparam int XT_ROUND_PAIRS = 32;
    localparam int XT_WORD_W      = 32;
    localparam int XT_CFG_IDX_W   = 3;

    // delta is applied as a subtraction of its negation
    localparam logic [XT_WORD_W-1:0] XT_DELTA_NEG = 32'h61C88647;

    // register indexes of the configuration port
    localparam logic [XT_CFG_IDX_W-1:0] KEY_IDX_0 = 3'd0;
    localparam logic [XT_CFG_IDX_W-1:0] KEY_IDX_1 = 3'd1;
    localparam logic [XT_CFG_IDX_W-1:0] KEY_IDX_2 = 3'd2;
    localparam logic [XT_CFG_IDX_W-1:0] KEY_IDX_3 = 3'd3;

    localparam bit OP_ENCRYPT = 1'b0;
    localparam bit OP_DECRYPT = 1'b1;

    typedef logic [3:0][XT_WORD_W-1:0] key_t;

    typedef struct packed {
        logic                 op;
        logic [XT_WORD_W-1:0] first_word;
        logic [XT_WORD_W-1:0] second_word;
    } stage_data_t;

    // running sum after n delta steps, modulo 2^32
    // decrypt start at 32 round pairs works out to 0xc6ef3720
    function automatic logic [XT_WORD_W-1:0] pair_sum(input int n);
        logic [XT_WORD_W-1:0] prod;
        prod = XT_WORD_W'(n) * XT_DELTA_NEG;
        return XT_WORD_W'(0) - prod;
    endfunction

    function automatic logic [XT_WORD_W-1:0] mix_word(input logic [XT_WORD_W-1:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

[rtl/xtea_key_regs.sv]
// key word registers written through the configuration port
// depends on xtea_pkg
`timescale 1ns / 1ps
`include "xtea_block_cipher_core_assert.svh"

module xtea_key_regs
    import xtea_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [XT_CFG_IDX_W-1:0] cfg_index,
    input  logic [XT_WORD_W-1:0]    cfg_data,
    output key_t                    key
);

    key_t key_reg;
    key_t key_next;
    logic cfg_beat;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign key       = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_beat)
        begin
            case (cfg_index)
                KEY_IDX_0: key_next[0] = cfg_data;
                KEY_IDX_1: key_next[1] = cfg_data;
                KEY_IDX_2: key_next[2] = cfg_data;
                KEY_IDX_3: key_next[3] = cfg_data;
                // writes past the last key word are dropped
                default:   key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    `XTEA_ASSERT_NEXT(a_key0_write, cfg_beat && cfg_index == KEY_IDX_0, key_reg[0] == $past(cfg_data))
    `XTEA_ASSERT_NEXT(a_key3_write, cfg_beat && cfg_index == KEY_IDX_3, key_reg[3] == $past(cfg_data))
    `XTEA_ASSERT_NEXT(a_key_hold, !cfg_beat || cfg_index[XT_CFG_IDX_W-1], $stable(key_reg))

endmodule

[rtl/xtea_half_round.sv]
// one pipelined xtea half-round with its own valid bit and ready
// depends on xtea_pkg
`timescale 1ns / 1ps
`include "xtea_block_cipher_core_assert.svh"

module xtea_half_round
    import xtea_pkg::*;
#(
    parameter int ROUND_PAIRS = XT_ROUND_PAIRS,
    parameter int STAGE       = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_t        key,
    input  logic        in_valid,
    output logic        in_ready,
    input  stage_data_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output stage_data_t out_data
);

    localparam bit EVEN = (STAGE % 2) == 0;
    localparam int PAIR = STAGE / 2;

    // sums are fixed per stage, only the direction picks between them
    localparam logic [XT_WORD_W-1:0] ENC_SUM =
        EVEN ? pair_sum(PAIR) : pair_sum(PAIR + 1);
    localparam logic [XT_WORD_W-1:0] DEC_SUM =
        EVEN ? pair_sum(ROUND_PAIRS - PAIR) : pair_sum(ROUND_PAIRS - PAIR - 1);
    localparam logic [1:0] ENC_KEY = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
    localparam logic [1:0] DEC_KEY = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

    logic                 valid_reg;
    logic                 valid_next;
    stage_data_t          data_reg;
    stage_data_t          data_next;
    logic                 in_beat;
    logic                 upd_first;
    logic [XT_WORD_W-1:0] src_word;
    logic [XT_WORD_W-1:0] tgt_word;
    logic [XT_WORD_W-1:0] sum_key;
    logic [XT_WORD_W-1:0] feed;
    logic [XT_WORD_W-1:0] new_word;

    assign in_ready  = !valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // encrypt updates the first word on even stages, decrypt on odd ones
    assign upd_first = in_data.op ^ EVEN;

    always_comb
    begin
        src_word = upd_first ? in_data.second_word : in_data.first_word;
        tgt_word = upd_first ? in_data.first_word : in_data.second_word;
        if (in_data.op == OP_DECRYPT)
        begin
            sum_key = DEC_SUM + key[DEC_KEY];
        end
        else
        begin
            sum_key = ENC_SUM + key[ENC_KEY];
        end
        feed     = mix_word(src_word) ^ sum_key;
        new_word = (in_data.op == OP_DECRYPT) ? (tgt_word - feed) : (tgt_word + feed);

        data_next = in_data;
        if (upd_first)
        begin
            data_next.first_word = new_word;
        end
        else
        begin
            data_next.second_word = new_word;
        end
    end

    always_comb
    begin
        if (in_beat)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            data_reg <= data_next;
        end
    end

    `XTEA_ASSERT_NEXT(a_hold_on_stall, valid_reg && !out_ready, valid_reg && $stable(data_reg))
    `XTEA_ASSERT_NEXT(a_fill_on_beat, in_beat, valid_reg && data_reg.op == $past(in_data.op))
    `XTEA_ASSERT_NEXT(a_drain_empty, out_ready && !in_beat, !valid_reg)

endmodule

[rtl/xtea_block_cipher_core.sv]
// xtea core: one half-round per stage; one 64-bit block per cycle while out_ready is high
// each stage refills as soon as its beat moves on
// reset clears every stage valid bit and sets all four key words to zero
// depends on xtea_pkg, xtea_key_regs, xtea_half_round
`timescale 1ns / 1ps

module xtea_block_cipher_core
    import xtea_pkg::*;
#(
    parameter int ROUND_PAIRS = XT_ROUND_PAIRS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [XT_CFG_IDX_W-1:0] cfg_index,
    input  logic [XT_WORD_W-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic [XT_WORD_W-1:0]    first_word,
    input  logic [XT_WORD_W-1:0]    second_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [XT_WORD_W-1:0]    out_first_word,
    output logic [XT_WORD_W-1:0]    out_second_word
);

    localparam int NUM_STAGES = 2 * ROUND_PAIRS;

    key_t                  key;
    logic [NUM_STAGES:0]   stage_valid;
    logic [NUM_STAGES:0]   stage_ready;
    stage_data_t           stage_data [NUM_STAGES+1];

    xtea_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    assign stage_valid[0]            = in_valid;
    assign in_ready                  = stage_ready[0];
    assign stage_data[0].op          = op;
    assign stage_data[0].first_word  = first_word;
    assign stage_data[0].second_word = second_word;

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        xtea_half_round #(
            .ROUND_PAIRS (ROUND_PAIRS),
            .STAGE       (s)
        ) u_half_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key),
            .in_valid  (stage_valid[s]),
            .in_ready  (stage_ready[s]),
            .in_data   (stage_data[s]),
            .out_valid (stage_valid[s+1]),
            .out_ready (stage_ready[s+1]),
            .out_data  (stage_data[s+1])
        );
    end

    // the last stage register doubles as the output register
    assign out_valid                = stage_valid[NUM_STAGES];
    assign stage_ready[NUM_STAGES]  = out_ready;
    assign out_first_word           = stage_data[NUM_STAGES].first_word;
    assign out_second_word          = stage_data[NUM_STAGES].second_word;

endmodule

[verif/tb_xtea_block_cipher_core.sv]
// self-checking testbench for xtea_block_cipher_core: keys, then blocks in both directions
// needs xtea_pkg and the core rtl; predicts each block with its own xtea round loop
`timescale 1ns / 1ps

module tb_xtea_block_cipher_core;
    import xtea_pkg::*;

    localparam logic [XT_WORD_W-1:0] DEC_SUM_START = 32'hC6EF3720;
    localparam logic [XT_WORD_W-1:0] ALL_ONES      = 32'hFFFFFFFF;
    // indexes past the key words: the core must ignore writes to them
    localparam logic [XT_CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd4;
    localparam logic [XT_CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam int DRAIN_CYCLES = 2 * XT_ROUND_PAIRS + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic                 op;
        logic [XT_WORD_W-1:0] first_word;
        logic [XT_WORD_W-1:0] second_word;
    } blk_in_t;

    typedef struct packed {
        logic [XT_WORD_W-1:0] first_word;
        logic [XT_WORD_W-1:0] second_word;
    } blk_out_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [XT_CFG_IDX_W-1:0] cfg_index = '0;
    logic [XT_WORD_W-1:0]    cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    op = OP_ENCRYPT;
    logic [XT_WORD_W-1:0]    first_word = '0;
    logic [XT_WORD_W-1:0]    second_word = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [XT_WORD_W-1:0]    out_first_word;
    logic [XT_WORD_W-1:0]    out_second_word;

    key_t     key_model = '0;
    blk_in_t  pending_blocks[$];
    blk_out_t expected_blocks[$];
    blk_in_t  next_blk;
    blk_out_t want_blk;

    int send_gap_max = 0;
    int stall_max    = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int ready_run    = 0;
    int cycle_count  = 0;
    int fail_count   = 0;
    int blocks_sent  = 0;
    int blocks_checked = 0;
    int enc_count    = 0;
    int dec_count    = 0;
    int key_settings = 1;

    xtea_block_cipher_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .first_word      (first_word),
        .second_word     (second_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_first_word  (out_first_word),
        .out_second_word (out_second_word)
    );

    always #5 clk = ~clk;

    function automatic logic [XT_WORD_W-1:0] feistel_mix(input logic [XT_WORD_W-1:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    function automatic blk_out_t cipher_predict(input blk_in_t b, input key_t k);
        logic [XT_WORD_W-1:0] y;
        logic [XT_WORD_W-1:0] z;
        logic [XT_WORD_W-1:0] s;
        blk_out_t             r;
        int                   i;
        y = b.first_word;
        z = b.second_word;
        if (b.op == OP_DECRYPT)
        begin
            s = DEC_SUM_START;
            for (i = 0; i < XT_ROUND_PAIRS; i++)
            begin
                z = z - (feistel_mix(y) ^ (s + k[s[12:11]]));
                s = s + XT_DELTA_NEG;
                y = y - (feistel_mix(z) ^ (s + k[s[1:0]]));
            end
        end
        else
        begin
            s = '0;
            for (i = 0; i < XT_ROUND_PAIRS; i++)
            begin
                y = y + (feistel_mix(z) ^ (s + k[s[1:0]]));
                s = s - XT_DELTA_NEG;
                z = z + (feistel_mix(y) ^ (s + k[s[12:11]]));
            end
        end
        r.first_word  = y;
        r.second_word = z;
        return r;
    endfunction

    // mostly uniform words, with corner values mixed in
    function automatic logic [XT_WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return ALL_ONES;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_block(input logic o, input logic [XT_WORD_W-1:0] w0,
                               input logic [XT_WORD_W-1:0] w1);
        blk_in_t b;
        b.op          = o;
        b.first_word  = w0;
        b.second_word = w1;
        pending_blocks.push_back(b);
    endtask

    // encrypt a block, then decrypt the predicted ciphertext under the same key
    task automatic queue_round_trip(input logic [XT_WORD_W-1:0] w0,
                                    input logic [XT_WORD_W-1:0] w1);
        blk_in_t  b;
        blk_out_t c;
        b.op          = OP_ENCRYPT;
        b.first_word  = w0;
        b.second_word = w1;
        c = cipher_predict(b, key_model);
        queue_block(OP_ENCRYPT, w0, w1);
        queue_block(OP_DECRYPT, c.first_word, c.second_word);
    endtask

    task automatic write_key_reg(input logic [XT_CFG_IDX_W-1:0] idx,
                                 input logic [XT_WORD_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= KEY_IDX_3)
            key_model[idx[1:0]] = data;
    endtask

    task automatic load_key(input key_t k);
        write_key_reg(KEY_IDX_0, k[0]);
        write_key_reg(KEY_IDX_1, k[1]);
        write_key_reg(KEY_IDX_2, k[2]);
        write_key_reg(KEY_IDX_3, k[3]);
        key_settings++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_pacing(input int gap_max, input int stall);
        @(negedge clk);
        send_gap_max = gap_max;
        stall_max    = stall;
    endtask

    task automatic queue_directed();
        int o;
        for (o = 0; o < 2; o++)
        begin
            queue_block(o[0], '0, '0);
            queue_block(o[0], ALL_ONES, ALL_ONES);
            queue_block(o[0], 32'h80000000, 32'h00000001);
            queue_block(o[0], 32'hAAAAAAAA, 32'h55555555);
        end
        queue_round_trip(32'h01234567, 32'h89ABCDEF);
    endtask

    // sender: bursts of random length, separated by random gaps when send_gap_max is nonzero
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                next_blk.op          = op;
                next_blk.first_word  = first_word;
                next_blk.second_word = second_word;
                expected_blocks.push_back(cipher_predict(next_blk, key_model));
                blocks_sent++;
                if (op == OP_DECRYPT)
                    dec_count++;
                else
                    enc_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_blocks.size() != 0)
                begin
                    next_blk = pending_blocks.pop_front();
                    in_valid    <= 1'b1;
                    op          <= next_blk.op;
                    first_word  <= next_blk.first_word;
                    second_word <= next_blk.second_word;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(20, 1);
                        gap_left = (send_gap_max == 0) ? 0 : $urandom_range(send_gap_max, 1);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: always ready when stall_max is zero, else alternating ready and stall runs of random length
    always @(posedge clk)
    begin
        if (stall_max == 0)
        begin
            out_ready <= 1'b1;
        end
        else if (ready_run == 0)
        begin
            out_ready <= ~out_ready;
            ready_run = out_ready ? $urandom_range(stall_max, 1) : $urandom_range(10, 1);
        end
        else
        begin
            ready_run--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                $error("result beat with nothing expected: %h %h",
                       out_first_word, out_second_word);
                fail_count++;
            end
            else
            begin
                want_blk = expected_blocks.pop_front();
                blocks_checked++;
                if (out_first_word !== want_blk.first_word)
                begin
                    $error("out_first_word: expected %h, actual %h",
                           want_blk.first_word, out_first_word);
                    fail_count++;
                end
                if (out_second_word !== want_blk.second_word)
                begin
                    $error("out_second_word: expected %h, actual %h",
                           want_blk.second_word, out_second_word);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        key_t k;
        int   p;
        int   n;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // key words straight out of reset are all zero
        set_pacing(0, 0);
        queue_directed();
        wait_idle();

        load_key({ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
        for (p = CFG_IDX_SPARE_LO; p <= CFG_IDX_SPARE_HI; p++)
            write_key_reg(p[XT_CFG_IDX_W-1:0], $urandom);
        set_pacing(4, 6);
        queue_directed();
        wait_idle();

        load_key({32'h00000001, 32'h80000000, ALL_ONES, 32'h00000000});
        set_pacing(0, 0);
        for (n = 0; n < 100; n++)
            queue_block(1'($urandom_range(1)), rand_word(), rand_word());
        wait_idle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            k = {$urandom, $urandom, $urandom, $urandom};
            load_key(k);
            write_key_reg(XT_CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO)),
                          $urandom);
            case (p % 3)
                0: set_pacing(3, 4);
                1: set_pacing(12, 24);
                default: set_pacing(0, 8);
            endcase
            n = 0;
            while (n < 84)
            begin
                if ($urandom_range(7) == 0)
                begin
                    queue_round_trip(rand_word(), rand_word());
                    n += 2;
                end
                else
                begin
                    queue_block(1'($urandom_range(1)), rand_word(), rand_word());
                    n++;
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("checked %0d of %0d blocks (%0d encrypt, %0d decrypt) under %0d keys,",
                 blocks_checked, blocks_sent, enc_count, dec_count, key_settings);
        $display("with sender gaps, receiver stalls and writes to unused register indexes");
        if (fail_count == 0 && expected_blocks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
